// ===== hw/rtl/lfs_pkg.sv =====
package lfs_pkg;

  localparam int unsigned PwmBits = 16;
  localparam logic [16:0] PwmMax = 17'((1 << PwmBits) - 1);
  localparam logic [16:0] OutMax = 17'(2 * ((1 << PwmBits) - 1));
  localparam logic [16:0] MidVal = 17'h00EFF;

  localparam logic [1:0] LvlOff = 2'd0;
  localparam logic [1:0] LvlMid = 2'd1;
  localparam logic [1:0] LvlMax = 2'd2;
  localparam logic [1:0] LvlCur = 2'd3;

  localparam logic [1:0] GeoPar = 2'd0;
  localparam logic [1:0] GeoSeq = 2'd1;

  localparam logic [1:0] RegGeom  = 2'd0;
  localparam logic [1:0] RegSteps = 2'd1;

  typedef enum logic [3:0] {
    CORE_IDLE,
    CORE_LOG_SQ,
    CORE_LOG_NRM,
    CORE_MUL,
    CORE_DIV,
    CORE_EXP_INIT,
    CORE_EXP_LOAD,
    CORE_EXP_SQRT,
    CORE_EXP_NEXT,
    CORE_DONE
  } core_state_e;

  typedef struct packed {
    logic [16:0] range_v;
    logic [15:0] k;
    logic [15:0] last;
    logic [16:0] lo;
  } core_req_t;

  function automatic logic [16:0] level_value(input logic [1:0] code);
    logic [16:0] v;
    case (code)
      LvlMid:  v = MidVal;
      LvlMax:  v = OutMax;
      default: v = '0;
    endcase
    return v;
  endfunction

  // returns {led1, led0}
  function automatic logic [31:0] split_duty(input logic [19:0] value, input logic par);
    logic [16:0] v;
    logic [15:0] a;
    logic [15:0] b;
    v = (value > {3'b0, OutMax}) ? OutMax : value[16:0];
    if (par) begin
      a = v[16:1];
      b = v[16:1];
    end else if (v < PwmMax) begin
      a = v[15:0];
      b = '0;
    end else begin
      a = PwmMax[15:0];
      b = 16'(v - PwmMax);
    end
    return {b, a};
  endfunction

endpackage

// ===== hw/rtl/lfs_core.sv =====
module lfs_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lfs_pkg::core_req_t req_i,
  output logic              done_o,
  output logic [19:0]       value_o
);
  import lfs_pkg::*;

  core_state_e st_q, st_d;
  logic [5:0]  cnt_q;
  logic [3:0]  i_q;
  logic [30:0] x_q;
  logic [61:0] p_q;
  logic [4:0]  n_q;
  logic [15:0] frac_q;
  logic [15:0] k_q;
  logic [15:0] last_q;
  logic [16:0] lo_q;
  logic [36:0] acc_q;
  logic [15:0] rem_q;
  logic [30:0] y_q;
  logic [63:0] rad_q;
  logic [63:0] root_q;
  logic [63:0] bit_q;

  logic [4:0]  n_lead;
  logic [31:0] sq;
  logic [16:0] dv_t;
  logic        dv_ge;
  logic [63:0] sum;
  logic [31:0] v_in;
  logic [4:0]  ei;
  logic [46:0] shl;
  logic [16:0] ex;

  always_comb begin
    n_lead = '0;
    for (int j = 0; j < 17; j++) begin
      if (req_i.range_v[j]) n_lead = 5'(j);
    end
  end

  assign sq    = p_q[61:30];
  assign dv_t  = {rem_q, acc_q[36]};
  assign dv_ge = dv_t >= {1'b0, last_q};
  assign sum   = root_q + bit_q;
  assign v_in  = acc_q[i_q] ? {y_q, 1'b0} : {1'b0, y_q};
  assign ei    = (acc_q[20:16] > 5'd16) ? 5'd16 : acc_q[20:16];
  assign shl   = ({16'b0, y_q} << ei) + 47'(1 << 29);
  assign ex    = shl[46:30];

  always_comb begin
    st_d = st_q;
    case (st_q)
      CORE_IDLE:     if (start_i) st_d = CORE_LOG_SQ;
      CORE_LOG_SQ:   st_d = CORE_LOG_NRM;
      CORE_LOG_NRM:  st_d = (cnt_q == 6'd15) ? CORE_MUL : CORE_LOG_SQ;
      CORE_MUL:      st_d = CORE_DIV;
      CORE_DIV:      if (cnt_q == 6'd36) st_d = CORE_EXP_INIT;
      CORE_EXP_INIT: st_d = CORE_EXP_LOAD;
      CORE_EXP_LOAD: st_d = CORE_EXP_SQRT;
      CORE_EXP_SQRT: if (cnt_q == 6'd31) st_d = CORE_EXP_NEXT;
      CORE_EXP_NEXT: st_d = (i_q == 4'd15) ? CORE_DONE : CORE_EXP_LOAD;
      CORE_DONE:     st_d = CORE_IDLE;
      default:       st_d = CORE_IDLE;
    endcase
  end

  always_comb begin
    done_o  = (st_q == CORE_DONE);
    value_o = 20'({3'b0, lo_q} + {3'b0, ex} - 20'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= CORE_IDLE;
      cnt_q <= '0;
      i_q   <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        CORE_IDLE:     cnt_q <= '0;
        CORE_LOG_NRM:  cnt_q <= (cnt_q == 6'd15) ? 6'd0 : cnt_q + 6'd1;
        CORE_DIV:      cnt_q <= cnt_q + 6'd1;
        CORE_EXP_INIT: i_q <= '0;
        CORE_EXP_LOAD: cnt_q <= '0;
        CORE_EXP_SQRT: cnt_q <= cnt_q + 6'd1;
        CORE_EXP_NEXT: i_q <= i_q + 4'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      CORE_IDLE: begin
        if (start_i) begin
          x_q    <= 31'({14'b0, req_i.range_v} << (5'd30 - n_lead));
          n_q    <= n_lead;
          frac_q <= '0;
          k_q    <= req_i.k;
          last_q <= req_i.last;
          lo_q   <= req_i.lo;
        end
      end
      CORE_LOG_SQ: p_q <= {31'b0, x_q} * {31'b0, x_q};
      CORE_LOG_NRM: begin
        if (sq[31]) begin
          x_q    <= sq[31:1];
          frac_q <= {frac_q[14:0], 1'b1};
        end else begin
          x_q    <= sq[30:0];
          frac_q <= {frac_q[14:0], 1'b0};
        end
      end
      CORE_MUL: begin
        acc_q <= {21'b0, k_q} * {16'b0, n_q, frac_q};
        rem_q <= '0;
      end
      CORE_DIV: begin
        rem_q <= dv_ge ? 16'(dv_t - {1'b0, last_q}) : dv_t[15:0];
        acc_q <= {acc_q[35:0], dv_ge};
      end
      CORE_EXP_INIT: y_q <= 31'(1 << 30);
      CORE_EXP_LOAD: begin
        rad_q  <= {2'b0, v_in, 30'b0};
        root_q <= '0;
        bit_q  <= 64'(1) << 62;
      end
      CORE_EXP_SQRT: begin
        if (rad_q >= sum) begin
          rad_q  <= rad_q - sum;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      CORE_EXP_NEXT: y_q <= root_q[30:0];
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/log_fade_two_led_split_top.sv =====
// Exponential LED fade, two channels. Each input transaction is one fade step;
// one output transaction follows with both duty values. Equal levels or
// fewer than two steps are answered in the next cycle; a real fade step runs
// through a shared sequencer (16 log2 squarings, each a square and a
// normalise, a bit-serial divide, then 16 square roots, each with load and
// store), so the result is registered once the sequencer reaches its done
// state, and the next input is taken only once that result has been taken.
// One step is in flight at a time; input is not taken while a result
// waits on the output. Config writes are taken at any time but belong in idle.
module log_fade_two_led_split_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] from_level, [3:2] to_level, [19:4] step_index, [36:20] current_pwm
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] led0_duty, [31:16] led1_duty
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);
  import lfs_pkg::*;

  logic [1:0]  geom_q;
  logic [15:0] steps_q;
  logic [1:0]  last_start_q;
  logic [16:0] capt_q;
  logic        busy_q;
  logic        par_q;
  logic        m_valid_q;
  logic [31:0] m_data_q;

  logic [1:0]  from_l, to_l;
  logic [15:0] step_in;
  logic [16:0] pwm_in, pwm_sat, capt_new, vto, vfrom, hi, lo;
  logic [15:0] last, stepc, k;
  logic        special, autom, rising, in_acc, core_done;
  logic [19:0] core_value;
  core_req_t   req;

  assign from_l  = s_axis_tdata[1:0];
  assign to_l    = s_axis_tdata[3:2];
  assign step_in = s_axis_tdata[19:4];
  assign pwm_in  = s_axis_tdata[36:20];

  assign s_axis_tready = !busy_q && !m_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    autom    = (geom_q != GeoPar) && (geom_q != GeoSeq);
    vto      = level_value(to_l);
    special  = (from_l == to_l) || (steps_q < 16'd2);
    pwm_sat  = (pwm_in > OutMax) ? OutMax : pwm_in;
    capt_new = (last_start_q != LvlCur) ? pwm_sat : capt_q;
    vfrom    = (from_l == LvlCur) ? capt_new : level_value(from_l);
    last     = steps_q - 16'd1;
    stepc    = (step_in > last) ? last : step_in;
    rising   = vfrom < vto;
    hi       = rising ? vto : vfrom;
    lo       = rising ? vfrom : vto;
    k        = rising ? stepc : 16'(last - stepc);
    req.range_v = 17'(hi - lo + 17'd1);
    req.k       = k;
    req.last    = last;
    req.lo      = lo;
  end

  lfs_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && !special),
    .req_i   (req),
    .done_o  (core_done),
    .value_o (core_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q       <= 2'd2;
      steps_q      <= 16'd256;
      last_start_q <= LvlOff;
      capt_q       <= '0;
      busy_q       <= 1'b0;
      m_valid_q    <= 1'b0;
      par_q        <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_addr_i == RegGeom)  geom_q  <= cfg_data_i[1:0];
        if (cfg_addr_i == RegSteps) steps_q <= cfg_data_i;
      end
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      if (in_acc) begin
        if (special) begin
          m_valid_q <= 1'b1;
        end else begin
          busy_q       <= 1'b1;
          par_q        <= autom ? !rising : (geom_q == GeoPar);
          last_start_q <= from_l;
          if (from_l == LvlCur) capt_q <= capt_new;
        end
      end
      if (core_done) begin
        busy_q    <= 1'b0;
        m_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && special) begin
      m_data_q <= split_duty({3'b0, (from_l == to_l) ? vto : 17'd0},
                             autom || (geom_q == GeoPar));
    end else if (core_done) begin
      m_data_q <= split_duty(core_value, par_q);
    end
  end

endmodule

// ===== hw/rtl/lfs_checker.sv =====
module lfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  a_no_take_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second transaction accepted back to back");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind log_fade_two_led_split_top lfs_checker u_lfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
